### rtl/circular_deque_assert.svh
// Assertion macros shared by the deque modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CDQ_ASSERT(lbl, prop, msg)
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/cdq_pkg.sv
package cdq_pkg;

  // Operation codes carried in the opcode field
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } opcode_e;

  // Completion codes carried in the status field
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned OccW  = 8;

  // One operation word
  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [WordW-1:0] push_value;
  } op_t;

  // One result word
  typedef struct packed {
    logic signed [WordW-1:0] popped_value;
    logic [1:0]              status;
    logic                    is_full;
    logic                    is_empty;
    logic [OccW-1:0]         occupancy;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
  } cmd_t;

  // Controller state
  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_e;

endpackage

### rtl/cdq_if.sv
// Operation channel
interface cdq_op_if import cdq_pkg::*; ();
  logic valid;
  logic ready;
  op_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Result channel
interface cdq_res_if import cdq_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/cdq_dpath.sv
`include "circular_deque_assert.svh"

module cdq_dpath import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  op_t  op_i,
  output res_t res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WordW-1:0] mem [DEPTH];

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [1:0]    status_d;
  logic          empty_now;
  logic          full_now;
  logic [CW+OccW-1:0] occ_ext;

  logic [WordW-1:0] rd_word_q;
  logic             pop_ok_q;
  logic [1:0]       status_q;
  logic             full_q;
  logic             empty_q;
  logic [OccW-1:0]  occ_q;

  // Step an index forward or back around the ring
  function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] idx);
    logic [AW-1:0] nxt;
    nxt = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] idx);
    logic [AW-1:0] nxt;
    nxt = (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
    return nxt;
  endfunction

  assign empty_now = (count_q == '0);
  assign full_now  = (count_q == CW'(DEPTH));

  // Decode the operation against the current occupancy
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    wr_addr  = '0;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    status_d = ST_DONE;
    case (opcode_e'(op_i.opcode))
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full_now) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (empty_now) begin
            head_d  = '0;
            tail_d  = '0;
            wr_addr = '0;
          end else if (opcode_e'(op_i.opcode) == OP_PUSH_FRONT) begin
            head_d  = step_back(head_q);
            wr_addr = head_d;
          end else begin
            tail_d  = step_fwd(tail_q);
            wr_addr = tail_d;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty_now) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          count_d = count_q - 1'b1;
          rd_addr = (opcode_e'(op_i.opcode) == OP_POP_FRONT) ? head_q : tail_q;
          if (head_q == tail_q) begin
            head_d = '0;
            tail_d = '0;
          end else if (opcode_e'(op_i.opcode) == OP_POP_FRONT) begin
            head_d = step_fwd(head_q);
          end else begin
            tail_d = step_back(tail_q);
          end
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  assign occ_ext = {{OccW{1'b0}}, count_d};

  // Advance the ring pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Store pushed words, read the popped word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      mem[wr_addr] <= op_i.push_value;
    end
    if (cmd_i.accept && rd_en) begin
      rd_word_q <= mem[rd_addr];
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pop_ok_q <= rd_en;
      status_q <= status_d;
      full_q   <= (count_d == CW'(DEPTH));
      empty_q  <= (count_d == '0);
      occ_q    <= occ_ext[OccW-1:0];
    end
  end

  assign res_o.popped_value = pop_ok_q ? rd_word_q : '0;
  assign res_o.status       = status_q;
  assign res_o.is_full      = full_q;
  assign res_o.is_empty     = empty_q;
  assign res_o.occupancy    = occ_q;

  `CDQ_ASSERT(a_count_range, count_q <= CW'(DEPTH), "fill count above depth")
  `CDQ_ASSERT(a_empty_ptrs, (count_q == '0) |-> (head_q == '0 && tail_q == '0),
              "empty deque with pointers away from zero")
  `CDQ_ASSERT(a_empty_flag, cmd_i.accept |=> (res_o.is_empty == (count_q == '0)),
              "reported empty flag disagrees with fill count")
  `CDQ_ASSERT(a_reject_hold, (cmd_i.accept && status_d != ST_DONE) |=> $stable(count_q),
              "rejected operation changed fill count")

endmodule

### rtl/cdq_ctrl.sv
`include "circular_deque_assert.svh"

module cdq_ctrl import cdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Take a word while the result register is free or being drained
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i && !in_valid_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o.accept = in_valid_i && in_ready_o;

  `CDQ_ASSERT(a_accept_result, cmd_o.accept |=> out_valid_o, "accepted word gave no result")
  `CDQ_ASSERT(a_no_overwrite, (out_valid_o && !out_ready_i) |-> !in_ready_o,
              "input taken while result stalled")
  `CDQ_ASSERT(a_free_ready, !out_valid_o |-> in_ready_o, "idle block refused input")
  `CDQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result shown during reset")

endmodule

### rtl/circular_deque.sv
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// Operation channel op_i carries an opcode (push front, push rear, pop front,
// pop rear) and a push word; result channel res_o carries the popped word,
// a status code (done, rejected full, rejected empty), the full and empty
// flags and the occupancy after the operation. Both use valid/ready; a word
// moves at a clock edge with valid and ready high.
// The result is valid in the cycle after its operation is taken.
// Throughput: one operation per cycle while results drain, set by the pointer
// update and the one write port / one registered read port of the ring memory.
// A result register parts the channels: while it is free or drained in the
// same cycle, op_i stays ready. When the receiver stalls, the result holds
// and op_i drops ready until it is taken.
// Reset (asynchronous, active low) empties the deque and clears both
// pointers; ring contents are left as they are and are never read before a
// push writes them. Occupancy wraps modulo 256 for DEPTH above 255.
module circular_deque import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input logic      clk_i,
  input logic      rst_ni,
  cdq_op_if.sink   op_i,
  cdq_res_if.source res_o
);

  cmd_t cmd;
  res_t res;
  logic in_ready;
  logic out_valid;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (op_i.valid),
    .out_ready_i (res_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .op_i   (op_i.payload),
    .res_o  (res)
  );

  assign op_i.ready    = in_ready;
  assign res_o.valid   = out_valid;
  assign res_o.payload = res;

endmodule
